// ----- design/lru_page_replacement_defines.svh -----
// ----------------------------------------------------------------------------
// lru page replacement assertion macros
// shared property forms for the checker
// ----------------------------------------------------------------------------
`ifndef LRU_PAGE_REPLACEMENT_DEFINES_SVH
`define LRU_PAGE_REPLACEMENT_DEFINES_SVH

// same-cycle implication
`define LRU_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lru page replacement: assertion failed");

// next-cycle implication
`define LRU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lru page replacement: assertion failed");

`endif

// ----- design/lru_pr_pkg.sv -----
// ----------------------------------------------------------------------------
// lru_pr_pkg
// shared constants and types of the lru page replacement block
// ----------------------------------------------------------------------------
package lru_pr_pkg;

   localparam int LRU_MAX_FRAMES = 5;
   localparam int LRU_PAGE_BITS  = 16;
   localparam int LRU_COUNT_BITS = 32;

   localparam int INDEX_BITS     = 3;
   localparam int CFG_BITS       = 3;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [CFG_BITS-1:0] FRAMES_RESET = 3'd5;

   typedef enum logic [0:0] {
      REG_FRAMES_IN_USE = 1'b0,
      REG_NONE          = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic hit;
      logic evicted_valid;
   } lru_flags_type;

endpackage

// ----- design/lru_pr_csr.sv -----
// ----------------------------------------------------------------------------
// lru_pr_csr
// configuration register file, frames in use
// ----------------------------------------------------------------------------
module lru_pr_csr import lru_pr_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     wr_en,
   input  reg_index_type            index,
   input  logic [CFG_BITS-1:0]      wr_data,
   output logic [CSR_DATA_BITS-1:0] rd_data,
   output logic [CFG_BITS-1:0]      frames_in_use
);

   logic [CFG_BITS-1:0] frames_ff;
   logic [CFG_BITS-1:0] frames_in;

   always_comb begin
      frames_in = frames_ff;
      rd_data   = '0;
      unique case (index)
         REG_FRAMES_IN_USE: begin
            if (wr_en) begin
               frames_in = wr_data;
            end
            rd_data = CSR_DATA_BITS'(frames_ff);
         end
         default: begin
            rd_data = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= FRAMES_RESET;
      end else begin
         frames_ff <= frames_in;
      end
   end

   assign frames_in_use = frames_ff;

endmodule

// ----- design/lru_pr_frames.sv -----
// ----------------------------------------------------------------------------
// lru_pr_frames
// frame store, recency ranks, hit and victim selection, counters
// ----------------------------------------------------------------------------
module lru_pr_frames import lru_pr_pkg::*; #(
   parameter int MAX_FRAMES = LRU_MAX_FRAMES,
   parameter int PAGE_BITS  = LRU_PAGE_BITS,
   parameter int COUNT_BITS = LRU_COUNT_BITS,
   localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1,
   localparam int PW = $clog2(MAX_FRAMES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  logic [PAGE_BITS-1:0]  page,
   input  logic                  last,
   input  logic [CFG_BITS-1:0]   frames_in_use,
   output lru_flags_type         flags,
   output logic [FW-1:0]         frame,
   output logic [PAGE_BITS-1:0]  evicted_page,
   output logic [COUNT_BITS-1:0] hit_total,
   output logic [COUNT_BITS-1:0] fault_total
);

   logic [PAGE_BITS-1:0]  pages_ff [MAX_FRAMES];
   logic [FW-1:0]         rank_ff  [MAX_FRAMES];
   logic [FW-1:0]         rank_in  [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] valid_ff;
   logic [MAX_FRAMES-1:0] valid_in;
   logic [PW-1:0]         fill_ff;
   logic [PW-1:0]         fill_in;
   logic [COUNT_BITS-1:0] hits_ff;
   logic [COUNT_BITS-1:0] hits_in;
   logic [COUNT_BITS-1:0] faults_ff;
   logic [COUNT_BITS-1:0] faults_in;

   logic [PW-1:0]         active;
   logic [MAX_FRAMES-1:0] in_range;
   logic [MAX_FRAMES-1:0] match;
   logic [MAX_FRAMES-1:0] oldest;
   logic                  hit;
   logic                  fill;
   logic [FW-1:0]         hit_idx;
   logic [FW-1:0]         vic_idx;
   logic [FW-1:0]         sel;
   logic [FW-1:0]         sel_rank;

   // active frame count, zero acts as one, clamp at the frame count
   always_comb begin
      if (frames_in_use == '0) begin
         active = PW'(1);
      end else if (int'(frames_in_use) > MAX_FRAMES) begin
         active = PW'(MAX_FRAMES);
      end else begin
         active = PW'(frames_in_use);
      end
   end

   always_comb begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         in_range[k] = int'(active) > k;
         match[k]    = in_range[k] && valid_ff[k] && (pages_ff[k] == page);
      end
   end

   // first oldest frame among the active ones
   always_comb begin
      for (int k = 0; k < MAX_FRAMES; k++) begin
         oldest[k] = in_range[k];
         for (int j = 0; j < MAX_FRAMES; j++) begin
            if (j < k && in_range[j] && rank_ff[k] <= rank_ff[j]) begin
               oldest[k] = 1'b0;
            end
            if (j > k && in_range[j] && rank_ff[k] < rank_ff[j]) begin
               oldest[k] = 1'b0;
            end
         end
      end
   end

   always_comb begin
      hit_idx = '0;
      vic_idx = '0;
      for (int k = MAX_FRAMES - 1; k >= 0; k--) begin
         if (match[k]) begin
            hit_idx = FW'(k);
         end
         if (oldest[k]) begin
            vic_idx = FW'(k);
         end
      end
   end

   assign hit  = |match;
   assign fill = !hit && (fill_ff < active);

   always_comb begin
      if (hit) begin
         sel = hit_idx;
      end else if (fill) begin
         sel = FW'(fill_ff);
      end else begin
         sel = vic_idx;
      end
   end

   assign sel_rank = rank_ff[sel];

   always_comb begin
      valid_in  = valid_ff;
      fill_in   = fill_ff;
      hits_in   = hits_ff;
      faults_in = faults_ff;
      for (int k = 0; k < MAX_FRAMES; k++) begin
         if (FW'(k) == sel) begin
            rank_in[k] = '0;
         end else if (valid_ff[k] && (fill || rank_ff[k] < sel_rank)) begin
            rank_in[k] = rank_ff[k] + FW'(1);
         end else begin
            rank_in[k] = rank_ff[k];
         end
      end
      if (hit) begin
         hits_in = (hits_ff == '1) ? hits_ff : hits_ff + COUNT_BITS'(1);
      end else begin
         faults_in = (faults_ff == '1) ? faults_ff : faults_ff + COUNT_BITS'(1);
      end
      if (fill) begin
         valid_in[sel] = 1'b1;
         fill_in       = fill_ff + PW'(1);
      end
   end

   assign flags.hit           = hit;
   assign flags.evicted_valid = !hit && !fill;
   assign frame               = sel;
   assign evicted_page        = (!hit && !fill) ? pages_ff[sel] : '0;
   assign hit_total           = hits_in;
   assign fault_total         = faults_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         fill_ff   <= '0;
         hits_ff   <= '0;
         faults_ff <= '0;
         for (int k = 0; k < MAX_FRAMES; k++) begin
            rank_ff[k] <= '0;
         end
      end else if (fire) begin
         if (last) begin
            valid_ff  <= '0;
            fill_ff   <= '0;
            hits_ff   <= '0;
            faults_ff <= '0;
            for (int k = 0; k < MAX_FRAMES; k++) begin
               rank_ff[k] <= '0;
            end
         end else begin
            valid_ff  <= valid_in;
            fill_ff   <= fill_in;
            hits_ff   <= hits_in;
            faults_ff <= faults_in;
            for (int k = 0; k < MAX_FRAMES; k++) begin
               rank_ff[k] <= rank_in[k];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (fire && !hit) begin
         pages_ff[sel] <= page;
      end
   end

endmodule

// ----- design/lru_page_replacement.sv -----
// ----------------------------------------------------------------------------
// lru_page_replacement
// fully associative lru page replacement over a configurable frame count
// ----------------------------------------------------------------------------
// usage
//   req channel: one page reference per item, with a flag for the last one
//   of a run. rsp channel: one result per item, hit or fault, frame used,
//   evicted page and saturating hit and fault totals. csr port: frames_in_use
//   at byte address 0, written only while idle: a user rule, not enforced.
// pipeline and throughput
//   an item sits in the input register, where the tag compare, victim
//   pick and rank update resolve, then moves to the result register;
//   one item per cycle while rsp does not stall.
// reset
//   all frames vacant, ranks, fill pointer and totals zero, frames_in_use
//   back to five. a result flagged run_end clears the run the same way.
// stall
//   a stalled result holds in the output register; the input register
//   still takes one more item, then req_stall rises until rsp drains.
// ----------------------------------------------------------------------------
module lru_page_replacement import lru_pr_pkg::*; #(
   parameter int MAX_FRAMES = LRU_MAX_FRAMES,
   parameter int PAGE_BITS  = LRU_PAGE_BITS,
   parameter int COUNT_BITS = LRU_COUNT_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [PAGE_BITS-1:0]     req_page_number,
   input  logic                     req_last_access,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic                     rsp_hit,
   output logic [INDEX_BITS-1:0]    rsp_frame_index,
   output logic                     rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]     rsp_evicted_page,
   output logic [COUNT_BITS-1:0]    rsp_hit_total,
   output logic [COUNT_BITS-1:0]    rsp_fault_total,
   output logic                     rsp_run_end,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   localparam int FW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;

   logic                  s_valid_ff;
   logic                  s_valid_in;
   logic [PAGE_BITS-1:0]  s_page_ff;
   logic                  s_last_ff;

   logic                  o_valid_ff;
   logic                  o_valid_in;
   logic                  o_hit_ff;
   logic [INDEX_BITS-1:0] o_frame_ff;
   logic                  o_ev_ff;
   logic [PAGE_BITS-1:0]  o_ev_page_ff;
   logic [COUNT_BITS-1:0] o_hits_ff;
   logic [COUNT_BITS-1:0] o_faults_ff;
   logic                  o_last_ff;

   logic                  accept;
   logic                  advance;
   logic                  csr_wr;
   logic [CFG_BITS-1:0]   frames_in_use;
   lru_flags_type         flags;
   logic [FW-1:0]         frame;
   logic [PAGE_BITS-1:0]  evicted_page;
   logic [COUNT_BITS-1:0] hit_total;
   logic [COUNT_BITS-1:0] fault_total;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   lru_pr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .wr_en         (csr_wr),
      .index         (reg_index_type'(csr_paddr[2])),
      .wr_data       (csr_pwdata[CFG_BITS-1:0]),
      .rd_data       (csr_prdata),
      .frames_in_use (frames_in_use)
   );

   assign advance   = s_valid_ff && (!o_valid_ff || !rsp_stall);
   assign req_stall = s_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      s_valid_in = s_valid_ff;
      if (accept) begin
         s_valid_in = 1'b1;
      end else if (advance) begin
         s_valid_in = 1'b0;
      end
      o_valid_in = o_valid_ff && rsp_stall;
      if (advance) begin
         o_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         o_valid_ff <= 1'b0;
      end else begin
         s_valid_ff <= s_valid_in;
         o_valid_ff <= o_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s_page_ff <= req_page_number;
         s_last_ff <= req_last_access;
      end
   end

   lru_pr_frames #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS),
      .COUNT_BITS (COUNT_BITS)
   ) u_frames (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .page          (s_page_ff),
      .last          (s_last_ff),
      .frames_in_use (frames_in_use),
      .flags         (flags),
      .frame         (frame),
      .evicted_page  (evicted_page),
      .hit_total     (hit_total),
      .fault_total   (fault_total)
   );

   always_ff @(posedge clock) begin
      if (advance) begin
         o_hit_ff     <= flags.hit;
         o_frame_ff   <= INDEX_BITS'(frame);
         o_ev_ff      <= flags.evicted_valid;
         o_ev_page_ff <= evicted_page;
         o_hits_ff    <= hit_total;
         o_faults_ff  <= fault_total;
         o_last_ff    <= s_last_ff;
      end
   end

   assign rsp_valid         = o_valid_ff;
   assign rsp_hit           = o_hit_ff;
   assign rsp_frame_index   = o_frame_ff;
   assign rsp_evicted_valid = o_ev_ff;
   assign rsp_evicted_page  = o_ev_page_ff;
   assign rsp_hit_total     = o_hits_ff;
   assign rsp_fault_total   = o_faults_ff;
   assign rsp_run_end       = o_last_ff;

endmodule

// ----- design/lru_pr_checker.sv -----
// ----------------------------------------------------------------------------
// lru_pr_checker
// port-level checks of the lru page replacement block
// ----------------------------------------------------------------------------
`include "lru_page_replacement_defines.svh"

module lru_pr_checker #(
   parameter int PAGE_BITS  = 16,
   parameter int COUNT_BITS = 32
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_stall,
   input logic                  rsp_hit,
   input logic                  rsp_evicted_valid,
   input logic [PAGE_BITS-1:0]  rsp_evicted_page,
   input logic [COUNT_BITS-1:0] rsp_hit_total,
   input logic [COUNT_BITS-1:0] rsp_fault_total
);

   // a hit never replaces a page
   `LRU_ASSERT_IMPLY(hit_no_evict, clock, reset, rsp_valid && rsp_hit, !rsp_evicted_valid)

   // no eviction reports page zero
   `LRU_ASSERT_IMPLY(evict_page_zero, clock, reset, rsp_valid && !rsp_evicted_valid, rsp_evicted_page == '0)

   // the total of this item's kind already counts it
   `LRU_ASSERT_IMPLY(total_counts_item, clock, reset, rsp_valid, (rsp_hit && rsp_hit_total != '0) || (!rsp_hit && rsp_fault_total != '0))

   // no result right after reset
   `LRU_ASSERT_NEXT(reset_clears_rsp, clock, 1'b0, reset, !rsp_valid)

   // a stalled result stays
   `LRU_ASSERT_NEXT(stall_holds_rsp, clock, reset, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind lru_page_replacement lru_pr_checker #(
   .PAGE_BITS  (PAGE_BITS),
   .COUNT_BITS (COUNT_BITS)
) u_checker (.*);
